// ===== src/fct_pkg.sv =====
// fct_pkg: shared constants, codes and types for the frustum cull test block.
// No dependencies; compile first.
package fct_pkg;

   localparam int COORD_WIDTH = 16;   // default coordinate width
   localparam int NUM_PLANES  = 6;
   localparam int NORM_W      = 16;   // Q1.14 normal components; signed integer offset
   localparam int FRAC_BITS   = 14;
   localparam int RADIUS_W    = 15;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 4 * NORM_W;

   typedef enum logic [1:0] {
      KIND_POINT  = 2'd0,
      KIND_SPHERE = 2'd1,
      KIND_BOX    = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      PLANE_LEFT   = 3'd0,
      PLANE_RIGHT  = 3'd1,
      PLANE_BOTTOM = 3'd2,
      PLANE_TOP    = 3'd3,
      PLANE_NEAR   = 3'd4,
      PLANE_FAR    = 3'd5
   } plane_index_type;

   // register write broadcast to every cell
   typedef struct packed {
      logic                   valid;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

endpackage

// ===== src/fct_req_if.sv =====
// fct_req_if: query channel (valid/ready plus query fields).
// Depends on fct_pkg.
interface fct_req_if #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH
);
   logic                              valid;
   logic                              ready;
   logic [1:0]                        kind;
   logic signed [COORD_WIDTH-1:0]     ax;
   logic signed [COORD_WIDTH-1:0]     ay;
   logic signed [COORD_WIDTH-1:0]     az;
   logic signed [COORD_WIDTH-1:0]     bx;
   logic signed [COORD_WIDTH-1:0]     by;
   logic signed [COORD_WIDTH-1:0]     bz;
   logic [fct_pkg::RADIUS_W-1:0]      radius;

   modport source (output valid, kind, ax, ay, az, bx, by, bz, radius, input ready);
   modport sink   (input valid, kind, ax, ay, az, bx, by, bz, radius, output ready);
endinterface

// ===== src/fct_rsp_if.sv =====
// fct_rsp_if: result channel (valid/ready plus inside flag).
// No dependencies.
interface fct_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

// ===== src/fct_csr_if.sv =====
// fct_csr_if: plane register write channel (valid/ready, index, data).
// Depends on fct_pkg.
interface fct_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fct_pkg::CSR_INDEX_W-1:0] index;
   logic [fct_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/frustum_cull_test.sv =====
// frustum_cull_test: top level; six plane cells in a chain with query and
// result channels and the plane register port. Depends on fct_pkg, the
// interfaces fct_req_if, fct_rsp_if, fct_csr_if and fct_cell.
//
// Tests each query (point, sphere or axis-aligned box) against six frustum
// planes and returns one transaction with inside_res set when all six pass.
// Planes are written through the csr channel (index 0..5: left, right,
// bottom, top, near, far; other indexes are dropped), which is always ready;
// write only while no query is in flight. The query walks a chain of six
// cells, one per plane, each with a product stage and a sum/compare stage,
// so each query is registered in both stages of every cell, and one query is
// taken every cycle while rsp_chan.ready stays high. Each cell has two
// register stages (three 16xN products, then one wide sum). The last cell's
// stage 2 is the output register; stalls back up the chain stage by stage,
// so free stages keep taking queries. Unknown kind codes return
// inside_res 0.
module frustum_cull_test #(
   parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   fct_req_if.sink   req_chan,
   fct_rsp_if.source rsp_chan,
   fct_csr_if.sink   csr_chan
);

   localparam int QUERY_W = 2 + 6 * COORD_WIDTH + fct_pkg::RADIUS_W + 1;

   typedef struct packed {
      fct_pkg::kind_type                 kind;
      logic [2:0][COORD_WIDTH-1:0]       lo;
      logic [2:0][COORD_WIDTH-1:0]       hi;
      logic [fct_pkg::RADIUS_W-1:0]      radius;
      logic                              pass;
   } query_type;

   logic                  chain_valid [fct_pkg::NUM_PLANES+1];
   logic                  chain_ready [fct_pkg::NUM_PLANES+1];
   logic [QUERY_W-1:0]    chain_query [fct_pkg::NUM_PLANES+1];
   query_type             entry_q;
   query_type             exit_q;
   fct_pkg::csr_write_type csr_wr;

   // register writes are taken every cycle
   assign csr_chan.ready = 1'b1;
   assign csr_wr.valid   = csr_chan.valid;
   assign csr_wr.index   = csr_chan.index;
   assign csr_wr.data    = csr_chan.data;

   // entry: pack the query; unknown kinds start out failed
   always_comb begin
      entry_q.kind   = fct_pkg::kind_type'(req_chan.kind);
      entry_q.lo[0]  = req_chan.ax;
      entry_q.lo[1]  = req_chan.ay;
      entry_q.lo[2]  = req_chan.az;
      entry_q.hi[0]  = req_chan.bx;
      entry_q.hi[1]  = req_chan.by;
      entry_q.hi[2]  = req_chan.bz;
      entry_q.radius = req_chan.radius;
      unique case (req_chan.kind)
         fct_pkg::KIND_POINT,
         fct_pkg::KIND_SPHERE,
         fct_pkg::KIND_BOX: begin
            entry_q.pass = 1'b1;
         end
         default: begin
            entry_q.pass = 1'b0;
         end
      endcase
   end

   assign chain_valid[0] = req_chan.valid;
   assign chain_query[0] = entry_q;
   assign req_chan.ready = chain_ready[0];

   for (genvar i = 0; i < fct_pkg::NUM_PLANES; i++) begin : g_cell
      fct_cell #(
         .COORD_WIDTH (COORD_WIDTH),
         .CELL_INDEX  (fct_pkg::plane_index_type'(i)),
         .QUERY_W     (QUERY_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_wr    (csr_wr),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_query  (chain_query[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_query (chain_query[i+1])
      );
   end

   // exit: last cell's output register drives the result channel
   assign exit_q                            = query_type'(chain_query[fct_pkg::NUM_PLANES]);
   assign rsp_chan.valid                    = chain_valid[fct_pkg::NUM_PLANES];
   assign rsp_chan.inside_res               = exit_q.pass;
   assign chain_ready[fct_pkg::NUM_PLANES]  = rsp_chan.ready;

endmodule

// ===== src/fct_cell.sv =====
// fct_cell: one plane of the chain; holds its plane register, multiplies then
// sums and compares, handing the query on. Depends on fct_pkg.
module fct_cell #(
   parameter int                       COORD_WIDTH = fct_pkg::COORD_WIDTH,
   parameter fct_pkg::plane_index_type CELL_INDEX  = fct_pkg::PLANE_LEFT,
   parameter int                       QUERY_W     =
      2 + 6 * COORD_WIDTH + fct_pkg::RADIUS_W + 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fct_pkg::csr_write_type csr_wr,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [QUERY_W-1:0]    in_query,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUERY_W-1:0]    out_query
);

   localparam int PROD_W = COORD_WIDTH + fct_pkg::NORM_W;
   localparam int OFF_W  = fct_pkg::NORM_W + fct_pkg::FRAC_BITS;
   localparam int SUM_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 3;

   typedef struct packed {
      fct_pkg::kind_type                 kind;
      logic [2:0][COORD_WIDTH-1:0]       lo;
      logic [2:0][COORD_WIDTH-1:0]       hi;
      logic [fct_pkg::RADIUS_W-1:0]      radius;
      logic                              pass;
   } query_type;

   logic [fct_pkg::CSR_DATA_W-1:0] plane_ff, plane_in;
   logic                           s1_v_ff, s1_v_in;
   query_type                      s1_q_ff, s1_q_in;
   logic signed [PROD_W-1:0]       s1_p_ff [3];
   logic signed [PROD_W-1:0]       s1_p_in [3];
   logic                           s2_v_ff, s2_v_in;
   query_type                      s2_q_ff, s2_q_in;

   query_type                      q_new;
   logic                           s2_ready;
   logic signed [SUM_W-1:0]        dist_sum;
   logic signed [SUM_W-1:0]        rad_term;

   assign q_new    = query_type'(in_query);
   assign s2_ready = !s2_v_ff || out_ready;
   assign in_ready = !s1_v_ff || s2_ready;

   // plane register
   always_comb begin
      plane_in = plane_ff;
      if (csr_wr.valid && (csr_wr.index == CELL_INDEX)) begin
         plane_in = csr_wr.data;
      end
   end

   // stage 1: corner pick and products
   always_comb begin
      logic signed [COORD_WIDTH-1:0]     coord;
      logic signed [fct_pkg::NORM_W-1:0] nrm;
      for (int k = 0; k < 3; k++) begin
         nrm = $signed(plane_ff[fct_pkg::NORM_W*k +: fct_pkg::NORM_W]);
         if ((q_new.kind == fct_pkg::KIND_BOX) && !nrm[fct_pkg::NORM_W-1]) begin
            coord = $signed(q_new.hi[k]);
         end else begin
            coord = $signed(q_new.lo[k]);
         end
         s1_p_in[k] = PROD_W'(nrm) * PROD_W'(coord);
      end
      s1_q_in = q_new;
      s1_v_in = in_ready ? in_valid : s1_v_ff;
   end

   // stage 2: signed distance plus sphere margin, sign test
   always_comb begin
      rad_term = '0;
      if (s1_q_ff.kind == fct_pkg::KIND_SPHERE) begin
         rad_term = SUM_W'($signed({1'b0, s1_q_ff.radius})) <<< fct_pkg::FRAC_BITS;
      end
      dist_sum = SUM_W'(s1_p_ff[0]) + SUM_W'(s1_p_ff[1]) + SUM_W'(s1_p_ff[2])
               + (SUM_W'($signed(plane_ff[fct_pkg::NORM_W*3 +: fct_pkg::NORM_W]))
                  <<< fct_pkg::FRAC_BITS)
               + rad_term;
      s2_q_in      = s1_q_ff;
      s2_q_in.pass = s1_q_ff.pass && !dist_sum[SUM_W-1];
      s2_v_in      = s2_ready ? s1_v_ff : s2_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_q_ff <= s1_q_in;
         for (int k = 0; k < 3; k++) begin
            s1_p_ff[k] <= s1_p_in[k];
         end
      end
      if (s1_v_ff && s2_ready) begin
         s2_q_ff <= s2_q_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_query = s2_q_ff;

`ifndef SYNTHESIS
   // a failed test is never undone further down the chain
   a_pass_no_rise: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_ready |=> !s2_q_ff.pass || $past(s1_q_ff.pass))
      else $error("pass flag set without upstream pass");

   // input is only blocked when both stages are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !in_ready |-> s1_v_ff && s2_v_ff)
      else $error("cell stalled with a free stage");

   // stage 1 moves into stage 2 when it may
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_ready |=> s2_v_ff)
      else $error("transaction lost between cell stages");
`endif

endmodule
